// ----- rtl/matrix_multiply_accumulate_defines.svh -----
// Assertion macros used by the checker module of the matrix multiply block.
`ifndef MATRIX_MULTIPLY_ACCUMULATE_DEFINES_SVH
`define MATRIX_MULTIPLY_ACCUMULATE_DEFINES_SVH

// Concurrent assertion sampled on the rising clock edge, switched off during reset.
`define MMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent assertion that also holds while reset is applied.
`define MMA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/mma_pkg.sv -----
`default_nettype none

package mma_pkg;

  // Store geometry: each store holds MAX_DIM by MAX_DIM entries in row-major order.
  localparam int MAX_DIM = 8;
  localparam int CELLS   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(CELLS);

  // Field widths fixed by the interface.
  localparam int IDX_W  = 3;
  localparam int DIM_W  = 4;
  localparam int ELEM_W = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = 48;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  // Configuration register indexes.
  localparam logic [1:0] REG_ROWS_M  = 2'd0;
  localparam logic [1:0] REG_COLS_N  = 2'd1;
  localparam logic [1:0] REG_INNER_K = 2'd2;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_WR_A    = 2'd0,
    OP_WR_B    = 2'd1,
    OP_WR_C    = 2'd2,
    OP_COMPUTE = 2'd3
  } mma_op_e;

  // Control tag that travels alongside each multiply-accumulate step.
  typedef struct packed {
    logic             vld;
    logic             first;
    logic             lastk;
    logic             last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mma_tag_t;

  // Dimension in use: zero counts as one, anything above MAX_DIM as MAX_DIM.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
    logic [DIM_W-1:0] res;
    if (r == '0) begin
      res = DIM_W'(1);
    end else if (r > DIM_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    return ADDR_W'(int'(r) * MAX_DIM + int'(c));
  endfunction

  function automatic logic in_range(input logic [IDX_W-1:0] r,
                                    input logic [IDX_W-1:0] c);
    return (int'(r) < MAX_DIM) && (int'(c) < MAX_DIM);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mma_ram.sv -----
`default_nettype none

// Simple dual-port memory: one write port, one read port with registered data.
module mma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/mma_seq.sv -----
`default_nettype none

// Walks i, j and k for a compute and issues one store read per cycle.
module mma_seq import mma_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              launch_i,
  input  wire logic [DIM_W-1:0]  rows_m_i,
  input  wire logic [DIM_W-1:0]  cols_n_i,
  input  wire logic [DIM_W-1:0]  inner_k_i,
  output logic                   busy_o,
  output logic [ADDR_W-1:0]      a_raddr_o,
  output logic [ADDR_W-1:0]      b_raddr_o,
  output logic [ADDR_W-1:0]      c_raddr_o,
  output mma_tag_t               tag_o
);

  logic             busy_q, busy_d;
  logic [DIM_W-1:0] m_q, n_q, k_q;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, kc_q, kc_d;
  logic             k_end, j_end, i_end;
  mma_tag_t         tag_d;

  assign k_end = ({1'b0, kc_q} == (k_q - DIM_W'(1)));
  assign j_end = ({1'b0, j_q} == (n_q - DIM_W'(1)));
  assign i_end = ({1'b0, i_q} == (m_q - DIM_W'(1)));

  // Read addresses for the current step.
  assign a_raddr_o = cell_addr(i_q, kc_q);
  assign b_raddr_o = cell_addr(kc_q, j_q);
  assign c_raddr_o = cell_addr(i_q, j_q);

  // Counter advance: k innermost, then column, then row.
  always_comb begin
    busy_d = busy_q;
    i_d    = i_q;
    j_d    = j_q;
    kc_d   = kc_q;
    if (launch_i) begin
      busy_d = 1'b1;
      i_d    = '0;
      j_d    = '0;
      kc_d   = '0;
    end else if (busy_q) begin
      if (k_end) begin
        kc_d = '0;
        if (j_end) begin
          j_d = '0;
          if (i_end) begin
            busy_d = 1'b0;
          end else begin
            i_d = i_q + IDX_W'(1);
          end
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end else begin
        kc_d = kc_q + IDX_W'(1);
      end
    end
  end

  always_comb begin
    tag_d.vld   = busy_q;
    tag_d.first = (kc_q == '0);
    tag_d.lastk = k_end;
    tag_d.last  = k_end && j_end && i_end;
    tag_d.row   = i_q;
    tag_d.col   = j_q;
  end

  // Control state; the tag is registered so that it lines up with the store read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      tag_o  <= '0;
      i_q    <= '0;
      j_q    <= '0;
      kc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      tag_o  <= tag_d;
      i_q    <= i_d;
      j_q    <= j_d;
      kc_q   <= kc_d;
    end
  end

  // Dimensions are captured once per compute.
  always_ff @(posedge clk_i) begin
    if (launch_i) begin
      m_q <= eff_dim(rows_m_i);
      n_q <= eff_dim(cols_n_i);
      k_q <= eff_dim(inner_k_i);
    end
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire

// ----- rtl/mma_mac.sv -----
`default_nettype none

// Shared multiply-accumulate unit: a registered multiply, then a saturating add.
module mma_mac import mma_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire mma_tag_t                 tag_i,
  input  wire logic signed [ELEM_W-1:0] a_rdata_i,
  input  wire logic signed [ELEM_W-1:0] b_rdata_i,
  input  wire logic signed [ACC_W-1:0]  c_rdata_i,
  output logic                          busy_o,
  output logic                          wb_en_o,
  output logic [ADDR_W-1:0]             wb_addr_o,
  output logic signed [ACC_W-1:0]       wb_data_o,
  output logic                          out_valid_o,
  output logic [IDX_W-1:0]              out_row_o,
  output logic [IDX_W-1:0]              out_col_o,
  output logic signed [ACC_W-1:0]       out_value_o,
  output logic                          last_o
);

  mma_tag_t                  s2_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   cinit_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [ACC_W-1:0]   base;
  logic signed [ACC_W:0]     sum;
  logic                      emit;

  // Product and starting C value, registered from the store read data.
  always_ff @(posedge clk_i) begin
    prod_q <= a_rdata_i * b_rdata_i;
    if (tag_i.first) begin
      cinit_q <= c_rdata_i;
    end
  end

  // Saturating accumulate; the first step of an element starts from the stored C.
  always_comb begin
    base = s2_q.first ? cinit_q : acc_q;
    sum  = (ACC_W+1)'(base) + (ACC_W+1)'(prod_q);
    case (sum[ACC_W:ACC_W-1])
      2'b01:   acc_d = ACC_MAX;
      2'b10:   acc_d = ACC_MIN;
      default: acc_d = sum[ACC_W-1:0];
    endcase
  end

  assign emit      = s2_q.vld && s2_q.lastk;
  assign wb_en_o   = emit;
  assign wb_addr_o = cell_addr(s2_q.row, s2_q.col);
  assign wb_data_o = acc_d;

  // Step tag and result strobes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q        <= '0;
      out_valid_o <= 1'b0;
      last_o      <= 1'b0;
    end else begin
      s2_q        <= tag_i;
      out_valid_o <= emit;
      last_o      <= emit && s2_q.last;
    end
  end

  // Accumulator and result registers.
  always_ff @(posedge clk_i) begin
    if (s2_q.vld) begin
      acc_q <= acc_d;
    end
    if (emit) begin
      out_row_o   <= s2_q.row;
      out_col_o   <= s2_q.col;
      out_value_o <= acc_d;
    end
  end

  assign busy_o = tag_i.vld || s2_q.vld;

endmodule

`default_nettype wire

// ----- rtl/matrix_multiply_accumulate.sv -----
// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+----------------------------------------
// command   | in        | start && !busy          | opcode, row, col, elem_value, acc_value
// config    | in        | cfg_valid_i, cfg_ready_o| cfg_index_i, cfg_wdata_i
// result    | out       | out_valid_o, one cycle  | out_row, out_col, out_value, last
//
// A load command raises no busy; loads may follow back to back.
// During a compute, m, n and k are the dimensions in use (zero counts as one, anything
// above 8 as 8); the shared multiply-accumulate unit does one step per cycle, set by the
// single read port of the A and B stores.
// Results leave one per element of C and cannot be stalled by the receiver.
// After reset the C store reads as zero through per-entry valid bits; A and B hold
// whatever was last written. The configuration port is always ready.
`default_nettype none

module matrix_multiply_accumulate import mma_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               opcode_i,
  input  wire logic [IDX_W-1:0]         row_i,
  input  wire logic [IDX_W-1:0]         col_i,
  input  wire logic signed [ELEM_W-1:0] elem_value_i,
  input  wire logic signed [ACC_W-1:0]  acc_value_i,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [1:0]               cfg_index_i,
  input  wire logic [DIM_W-1:0]         cfg_wdata_i,
  output logic                          out_valid_o,
  output logic [IDX_W-1:0]              out_row_o,
  output logic [IDX_W-1:0]              out_col_o,
  output logic signed [ACC_W-1:0]       out_value_o,
  output logic                          last_o
);

  logic [DIM_W-1:0]         rows_m_q, cols_n_q, inner_k_q;
  logic                     accept, seq_busy, mac_busy, launch;
  logic                     ld_a, ld_b, ld_c, ld_ok;
  logic [ADDR_W-1:0]        ld_addr;
  logic [ADDR_W-1:0]        a_raddr, b_raddr, c_raddr;
  logic [ELEM_W-1:0]        a_rdata, b_rdata;
  logic [ACC_W-1:0]         c_rdata, c_rdata_gated;
  logic                     c_we;
  logic [ADDR_W-1:0]        c_waddr;
  logic [ACC_W-1:0]         c_wdata;
  logic                     wb_en;
  logic [ADDR_W-1:0]        wb_addr;
  logic signed [ACC_W-1:0]  wb_data;
  logic [CELLS-1:0]         c_vld_q;
  logic                     c_rvld_q;
  mma_tag_t                 tag;

  assign busy        = seq_busy || mac_busy;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // Command decode.
  always_comb begin
    ld_a   = 1'b0;
    ld_b   = 1'b0;
    ld_c   = 1'b0;
    launch = 1'b0;
    unique case (mma_op_e'(opcode_i))
      OP_WR_A:    ld_a   = accept && ld_ok;
      OP_WR_B:    ld_b   = accept && ld_ok;
      OP_WR_C:    ld_c   = accept && ld_ok;
      OP_COMPUTE: launch = accept;
      default:    launch = 1'b0;
    endcase
  end

  assign ld_ok   = in_range(row_i, col_i);
  assign ld_addr = cell_addr(row_i, col_i);

  // Configuration registers keep the written bits; clamping happens at use.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_m_q  <= DIM_RESET;
      cols_n_q  <= DIM_RESET;
      inner_k_q <= DIM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_ROWS_M:  rows_m_q  <= cfg_wdata_i;
        REG_COLS_N:  cols_n_q  <= cfg_wdata_i;
        REG_INNER_K: inner_k_q <= cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  mma_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .launch_i  (launch),
    .rows_m_i  (rows_m_q),
    .cols_n_i  (cols_n_q),
    .inner_k_i (inner_k_q),
    .busy_o    (seq_busy),
    .a_raddr_o (a_raddr),
    .b_raddr_o (b_raddr),
    .c_raddr_o (c_raddr),
    .tag_o     (tag)
  );

  mma_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_a_store (
    .clk_i   (clk_i),
    .we_i    (ld_a),
    .waddr_i (ld_addr),
    .wdata_i (elem_value_i),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mma_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_b_store (
    .clk_i   (clk_i),
    .we_i    (ld_b),
    .waddr_i (ld_addr),
    .wdata_i (elem_value_i),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // C store write port: loads while idle, write-back while computing.
  assign c_we    = ld_c || wb_en;
  assign c_waddr = wb_en ? wb_addr : ld_addr;
  assign c_wdata = wb_en ? wb_data : acc_value_i;

  mma_ram #(.WIDTH(ACC_W), .DEPTH(CELLS)) u_c_store (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  // Valid bits make never-written C entries read as zero after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q  <= '0;
      c_rvld_q <= 1'b0;
    end else begin
      c_rvld_q <= c_vld_q[c_raddr];
      if (c_we) begin
        c_vld_q[c_waddr] <= 1'b1;
      end
    end
  end

  assign c_rdata_gated = c_rvld_q ? c_rdata : '0;

  mma_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (tag),
    .a_rdata_i   (a_rdata),
    .b_rdata_i   (b_rdata),
    .c_rdata_i   (c_rdata_gated),
    .busy_o      (mac_busy),
    .wb_en_o     (wb_en),
    .wb_addr_o   (wb_addr),
    .wb_data_o   (wb_data),
    .out_valid_o (out_valid_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .out_value_o (out_value_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

// ----- rtl/mma_checker.sv -----
`default_nettype none

`include "matrix_multiply_accumulate_defines.svh"

// Port-level checks on the command and result behaviour of the block.
module mma_checker import mma_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] opcode_i,
  input wire logic       out_valid_o,
  input wire logic       last_o
);

  // A compute transaction occupies the block from the next cycle.
  `MMA_ASSERT(a_compute_busy, (start && !busy && (opcode_i == OP_COMPUTE)) |=> busy, "compute did not raise busy")

  // Results only come from a compute that was running in the previous cycle.
  `MMA_ASSERT(a_result_in_compute, out_valid_o |-> $past(busy), "result outside a compute")

  // The final result ends the compute; earlier ones leave it running.
  `MMA_ASSERT(a_last_ends, (out_valid_o && last_o) |-> !busy, "busy after the final result")
  `MMA_ASSERT(a_more_to_come, (out_valid_o && !last_o) |-> busy, "compute ended without final result")

  // The final flag is never shown without a result.
  `MMA_ASSERT_ALWAYS(a_last_marked, last_o |-> out_valid_o, "last without result strobe")

endmodule

bind matrix_multiply_accumulate mma_checker u_mma_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .opcode_i    (opcode_i),
  .out_valid_o (out_valid_o),
  .last_o      (last_o)
);

`default_nettype wire
